[rtl/btn_pkg.sv]
// shared types, constants and helper functions of the threshold network engine
package btn_pkg;

  localparam int MAX_LAYERS = 6;
  localparam int MAX_NODES  = 32;
  localparam int VALUE_BITS = 16;
  localparam int ROW_LEN    = MAX_NODES + 1;
  localparam int NODE_W     = 5;
  localparam int SEL_W      = 6;
  localparam int MATRIX_W   = 3;
  localparam int SUM_W      = 24;
  localparam int COUNT_W    = 6;
  localparam int ADDR_W_MAX = $clog2((MAX_LAYERS - 1) * MAX_NODES * ROW_LEN);
  localparam int NUM_SIZES  = 6;
  localparam int LC_W       = 3;
  localparam int REG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 5;
  localparam int CMD_DEPTH  = 4;
  localparam int OUT_DEPTH  = 4;

  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  localparam logic [REG_IDX_W-1:0] REG_LAYER_COUNT = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SIZE_FIRST  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_SIZE_LAST   = 3'd6;

  typedef struct packed {
    logic                         kind;
    logic [MATRIX_W-1:0]          matrix_sel;
    logic [NODE_W-1:0]            dest_node;
    logic [SEL_W-1:0]             source_sel;
    logic signed [VALUE_BITS-1:0] value;
    logic                         last_sample;
  } in_item_t;

  typedef struct packed {
    logic [NODE_W-1:0] out_node;
    logic              spike;
    logic              last_result;
    logic              size_error;
  } out_item_t;

  typedef struct packed {
    logic [LC_W-1:0]                       layer_count;
    logic [NUM_SIZES-1:0][COUNT_W-1:0]     size;
  } cfg_t;

  // front to back request: a store write or an inference start
  typedef struct packed {
    logic                         run;
    logic                         err;
    logic [ADDR_W_MAX-1:0]        addr;
    logic signed [VALUE_BITS-1:0] data;
    logic signed [SUM_W-1:0]      sum;
  } cmd_t;

  function automatic logic [COUNT_W-1:0] sat_size(input logic [COUNT_W-1:0] s);
    logic [COUNT_W-1:0] r;
    r = s;
    if (s == '0) begin
      r = COUNT_W'(1);
    end else if (s > COUNT_W'(MAX_NODES)) begin
      r = COUNT_W'(MAX_NODES);
    end
    return r;
  endfunction

  // row of (matrix, dest) holds MAX_NODES weights and the bias
  function automatic logic [ADDR_W_MAX-1:0] store_addr(input logic [MATRIX_W-1:0] m,
                                                        input logic [NODE_W-1:0]   n,
                                                        input logic [SEL_W-1:0]    s);
    logic [ADDR_W_MAX-1:0] row;
    row = ADDR_W_MAX'({m, n});
    return row * ADDR_W_MAX'(ROW_LEN) + ADDR_W_MAX'(s);
  endfunction

endpackage

[rtl/binary_threshold_net_inference_unit.sv]
// top level of the binary threshold network inference engine
//
//  channel  | ports                                         | request moves
//  ---------+-----------------------------------------------+---------------------------
//  input    | push, full, in_item                           | push && !full
//  result   | empty, pop, out_item                          | pop && !empty
//  config   | psel, penable, pwrite, paddr, pwdata, prdata  | psel && penable && pwrite
//
// weight loads and samples are taken one per cycle until the request queue fills.
// a run walks the weight store through its single read port: layer one reads one bias
// per node, each deeper layer L reads size(L-1) weights and a bias per node, then the
// results are emitted; loads behind a run wait in the request queue meanwhile.
// synchronous active-low reset clears queues and counters; the store is not cleared.
// a stalled result side holds the back end once the result queue is full.
module binary_threshold_net_inference_unit #(
  parameter int MAX_LAYERS = btn_pkg::MAX_LAYERS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               push,
  output logic                               full,
  input  btn_pkg::in_item_t                  in_item,
  output logic                               empty,
  input  logic                               pop,
  output btn_pkg::out_item_t                 out_item,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [btn_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [btn_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [btn_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                               pready
);

  localparam int CMD_W = $bits(btn_pkg::cmd_t);
  localparam int OUT_W = $bits(btn_pkg::out_item_t);

  logic [btn_pkg::LC_W-1:0]                              layer_count_r;
  logic [btn_pkg::NUM_SIZES-1:0][btn_pkg::COUNT_W-1:0]   size_r;
  logic [btn_pkg::REG_IDX_W-1:0]                         reg_idx;
  logic [btn_pkg::REG_IDX_W-1:0]                         size_idx;
  logic                                                  cfg_wr;
  btn_pkg::cfg_t                                         cfg;

  logic               accept;
  logic               cmd_push, cmd_full, cmd_empty, cmd_pop;
  btn_pkg::cmd_t      cmd_in, cmd_head;
  logic [CMD_W-1:0]   cmd_rd_data;
  logic               res_push, res_full;
  btn_pkg::out_item_t res_in;
  logic [OUT_W-1:0]   res_rd_data;

  // register file
  assign pready   = 1'b1;
  assign reg_idx  = paddr[btn_pkg::CFG_ADDR_W-1:2];
  assign size_idx = reg_idx - btn_pkg::REG_SIZE_FIRST;
  assign cfg_wr   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      layer_count_r <= btn_pkg::LC_W'(2);
      for (int i = 0; i < btn_pkg::NUM_SIZES; i++) begin
        size_r[i] <= btn_pkg::COUNT_W'(1);
      end
    end else if (cfg_wr) begin
      if (reg_idx == btn_pkg::REG_LAYER_COUNT) begin
        layer_count_r <= pwdata[btn_pkg::LC_W-1:0];
      end else if (reg_idx <= btn_pkg::REG_SIZE_LAST) begin
        size_r[size_idx] <= pwdata[btn_pkg::COUNT_W-1:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == btn_pkg::REG_LAYER_COUNT) begin
      prdata = btn_pkg::CFG_DATA_W'(layer_count_r);
    end else if (reg_idx <= btn_pkg::REG_SIZE_LAST) begin
      prdata = btn_pkg::CFG_DATA_W'(size_r[size_idx]);
    end
  end

  assign cfg.layer_count = layer_count_r;
  assign cfg.size        = size_r;

  assign full   = cmd_full;
  assign accept = push && !cmd_full;

  btn_front #(
    .MAX_LAYERS (MAX_LAYERS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .item     (in_item),
    .size0    (size_r[0]),
    .cmd_push (cmd_push),
    .cmd_item (cmd_in)
  );

  btn_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (btn_pkg::CMD_DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cmd_push),
    .wr_data (cmd_in),
    .full    (cmd_full),
    .rd_en   (cmd_pop),
    .rd_data (cmd_rd_data),
    .empty   (cmd_empty)
  );

  assign cmd_head = btn_pkg::cmd_t'(cmd_rd_data);

  btn_back #(
    .MAX_LAYERS (MAX_LAYERS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .c_empty (cmd_empty),
    .c_item  (cmd_head),
    .c_pop   (cmd_pop),
    .o_full  (res_full),
    .o_push  (res_push),
    .o_item  (res_in)
  );

  btn_fifo #(
    .WIDTH (OUT_W),
    .DEPTH (btn_pkg::OUT_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_push),
    .wr_data (res_in),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (res_rd_data),
    .empty   (empty)
  );

  assign out_item = btn_pkg::out_item_t'(res_rd_data);

endmodule

[rtl/btn_ram.sv]
// generic single write, single read ram with registered read data
module btn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/btn_fifo.sv]
// small register queue used between front and back and on the result side
module btn_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]      count_r, count_nxt;
  logic             do_wr, do_rd;

  assign full    = (count_r == (AW+1)'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + (AW+1)'(1);
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - (AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

[rtl/btn_front.sv]
// front end: takes items, sums samples, turns them into store writes and run requests
module btn_front #(
  parameter int MAX_LAYERS = btn_pkg::MAX_LAYERS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              accept,
  input  btn_pkg::in_item_t                 item,
  input  logic [btn_pkg::COUNT_W-1:0]       size0,
  output logic                              cmd_push,
  output btn_pkg::cmd_t                     cmd_item
);

  localparam logic [btn_pkg::MATRIX_W-1:0] MATRIX_LIMIT = btn_pkg::MATRIX_W'(MAX_LAYERS - 1);
  localparam logic [btn_pkg::SEL_W-1:0]    BIAS_SEL     = btn_pkg::SEL_W'(btn_pkg::MAX_NODES);
  localparam logic [btn_pkg::COUNT_W-1:0]  COUNT_SAT    = '1;

  logic signed [btn_pkg::SUM_W-1:0] sum_r, sum_nxt, sum_add;
  logic [btn_pkg::COUNT_W-1:0]      count_r, count_nxt, count_inc;
  logic                             load_ok;
  logic                             is_sample;

  assign is_sample = (item.kind == btn_pkg::KIND_SAMPLE);
  assign sum_add   = sum_r + {{(btn_pkg::SUM_W - btn_pkg::VALUE_BITS){item.value[btn_pkg::VALUE_BITS-1]}},
                              item.value};
  assign count_inc = (count_r == COUNT_SAT) ? count_r : count_r + btn_pkg::COUNT_W'(1);
  assign load_ok   = (item.matrix_sel < MATRIX_LIMIT) && (item.source_sel <= BIAS_SEL);

  always_comb begin
    cmd_push       = accept && (is_sample ? item.last_sample : load_ok);
    cmd_item.run   = is_sample;
    cmd_item.err   = (count_inc != btn_pkg::sat_size(size0));
    cmd_item.addr  = btn_pkg::store_addr(item.matrix_sel, item.dest_node, item.source_sel);
    cmd_item.data  = item.value;
    cmd_item.sum   = sum_add;
  end

  always_comb begin
    sum_nxt   = sum_r;
    count_nxt = count_r;
    if (accept && is_sample) begin
      if (item.last_sample) begin
        sum_nxt   = '0;
        count_nxt = '0;
      end else begin
        sum_nxt   = sum_add;
        count_nxt = count_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      count_r <= '0;
    end else begin
      sum_r   <= sum_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

[rtl/btn_back.sv]
// back end: owns the weight store, writes it and walks it layer by layer on a run
module btn_back #(
  parameter int MAX_LAYERS = btn_pkg::MAX_LAYERS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  btn_pkg::cfg_t        cfg,
  input  logic                 c_empty,
  input  btn_pkg::cmd_t        c_item,
  output logic                 c_pop,
  input  logic                 o_full,
  output logic                 o_push,
  output btn_pkg::out_item_t   o_item
);

  localparam int STORE_DEPTH = (MAX_LAYERS - 1) * btn_pkg::MAX_NODES * btn_pkg::ROW_LEN;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int NW          = btn_pkg::NODE_W;
  localparam int CW          = btn_pkg::COUNT_W;
  localparam int SW          = btn_pkg::SUM_W;
  localparam int VW          = btn_pkg::VALUE_BITS;
  localparam logic [btn_pkg::LC_W-1:0]    NL_MAX   = btn_pkg::LC_W'(MAX_LAYERS);
  localparam logic [btn_pkg::LC_W-1:0]    NL_MIN   = btn_pkg::LC_W'(2);
  localparam logic [btn_pkg::SEL_W-1:0]   BIAS_SEL = btn_pkg::SEL_W'(btn_pkg::MAX_NODES);
  localparam logic [btn_pkg::LC_W-1:0]    FIRST_LAYER = btn_pkg::LC_W'(1);

  typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_DRAIN, ST_EMIT} state_t;

  state_t                      state_r, state_nxt;
  logic [btn_pkg::LC_W-1:0]    layer_r, layer_nxt;
  logic [NW-1:0]               node_r, node_nxt;
  logic [CW-1:0]               src_r, src_nxt;
  logic [CW-1:0]               prev_r, prev_nxt;
  logic [CW-1:0]               cur_size_r, cur_size_nxt;
  logic [NW-1:0]               emit_r, emit_nxt;
  logic signed [SW-1:0]        sum_r, sum_nxt;
  logic signed [SW-1:0]        acc_r, acc_nxt;
  logic [btn_pkg::MAX_NODES-1:0] fire_cur_r, fire_cur_nxt;
  logic [btn_pkg::MAX_NODES-1:0] fire_new_r, fire_new_nxt;
  logic                        rd_v_r, rd_v_nxt;
  logic                        rd_bias_r, rd_bias_nxt;
  logic                        rd_use_r, rd_use_nxt;
  logic [NW-1:0]               rd_node_r, rd_node_nxt;

  logic [btn_pkg::LC_W-1:0]    nl, last_layer;
  logic                        at_bias;
  logic [btn_pkg::SEL_W-1:0]   rd_sel;
  logic [btn_pkg::ADDR_W_MAX-1:0] rd_addr_full;
  logic [VW-1:0]               ram_rdata;
  logic                        ram_we;
  logic signed [SW-1:0]        base;
  logic signed [SW:0]          eval_sum;
  logic signed [SW-1:0]        wt_ext;
  logic                        emit_last;

  always_comb begin
    nl = cfg.layer_count;
    if (cfg.layer_count < NL_MIN) begin
      nl = NL_MIN;
    end else if (cfg.layer_count > NL_MAX) begin
      nl = NL_MAX;
    end
  end
  assign last_layer = nl - btn_pkg::LC_W'(1);

  assign at_bias      = (src_r == prev_r);
  assign rd_sel       = at_bias ? BIAS_SEL : src_r;
  assign rd_addr_full = btn_pkg::store_addr(layer_r - btn_pkg::LC_W'(1), node_r, rd_sel);

  btn_ram #(
    .WIDTH (VW),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (c_item.addr[ADDR_W-1:0]),
    .wdata (c_item.data),
    .raddr (rd_addr_full[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  // layer one compares the input sum, deeper layers the weight accumulator
  assign base     = (layer_r == FIRST_LAYER) ? sum_r : acc_r;
  assign wt_ext   = {{(SW - VW){ram_rdata[VW-1]}}, ram_rdata};
  assign eval_sum = {base[SW-1], base} + {wt_ext[SW-1], wt_ext};
  assign emit_last = ({1'b0, emit_r} == cur_size_r - CW'(1));

  always_comb begin
    state_nxt    = state_r;
    layer_nxt    = layer_r;
    node_nxt     = node_r;
    src_nxt      = src_r;
    prev_nxt     = prev_r;
    cur_size_nxt = cur_size_r;
    emit_nxt     = emit_r;
    sum_nxt      = sum_r;
    acc_nxt      = acc_r;
    fire_cur_nxt = fire_cur_r;
    fire_new_nxt = fire_new_r;
    rd_v_nxt     = 1'b0;
    rd_bias_nxt  = rd_bias_r;
    rd_use_nxt   = rd_use_r;
    rd_node_nxt  = rd_node_r;
    c_pop        = 1'b0;
    ram_we       = 1'b0;
    o_push       = 1'b0;
    o_item       = '0;

    // read data of the previous cycle's step
    if (rd_v_r) begin
      if (rd_bias_r) begin
        fire_new_nxt[rd_node_r] = ~eval_sum[SW];
        acc_nxt                 = '0;
      end else if (rd_use_r) begin
        acc_nxt = acc_r + wt_ext;
      end
    end

    case (state_r)
      ST_IDLE: begin
        if (!c_empty) begin
          if (!c_item.run) begin
            ram_we = 1'b1;
            c_pop  = 1'b1;
          end else if (c_item.err) begin
            if (!o_full) begin
              o_push             = 1'b1;
              o_item.last_result = 1'b1;
              o_item.size_error  = 1'b1;
              c_pop              = 1'b1;
            end
          end else begin
            c_pop        = 1'b1;
            sum_nxt      = c_item.sum;
            acc_nxt      = '0;
            layer_nxt    = FIRST_LAYER;
            node_nxt     = '0;
            src_nxt      = '0;
            prev_nxt     = '0;
            cur_size_nxt = btn_pkg::sat_size(cfg.size[FIRST_LAYER]);
            state_nxt    = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        rd_v_nxt    = 1'b1;
        rd_bias_nxt = at_bias;
        rd_use_nxt  = fire_cur_r[src_r[NW-1:0]];
        rd_node_nxt = node_r;
        if (at_bias) begin
          src_nxt = '0;
          if ({1'b0, node_r} == cur_size_r - CW'(1)) begin
            state_nxt = ST_DRAIN;
          end else begin
            node_nxt = node_r + NW'(1);
          end
        end else begin
          src_nxt = src_r + CW'(1);
        end
      end
      ST_DRAIN: begin
        // last bias lands this cycle, so take the merged vector
        fire_cur_nxt = fire_new_nxt;
        if (layer_r == last_layer) begin
          emit_nxt  = '0;
          state_nxt = ST_EMIT;
        end else begin
          layer_nxt    = layer_r + btn_pkg::LC_W'(1);
          prev_nxt     = cur_size_r;
          cur_size_nxt = btn_pkg::sat_size(cfg.size[layer_r + btn_pkg::LC_W'(1)]);
          node_nxt     = '0;
          src_nxt      = '0;
          state_nxt    = ST_WALK;
        end
      end
      ST_EMIT: begin
        if (!o_full) begin
          o_push             = 1'b1;
          o_item.out_node    = emit_r;
          o_item.spike       = fire_cur_r[emit_r];
          o_item.last_result = emit_last;
          if (emit_last) begin
            state_nxt = ST_IDLE;
          end else begin
            emit_nxt = emit_r + NW'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      rd_v_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rd_v_r  <= rd_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    layer_r    <= layer_nxt;
    node_r     <= node_nxt;
    src_r      <= src_nxt;
    prev_r     <= prev_nxt;
    cur_size_r <= cur_size_nxt;
    emit_r     <= emit_nxt;
    sum_r      <= sum_nxt;
    acc_r      <= acc_nxt;
    fire_cur_r <= fire_cur_nxt;
    fire_new_r <= fire_new_nxt;
    rd_bias_r  <= rd_bias_nxt;
    rd_use_r   <= rd_use_nxt;
    rd_node_r  <= rd_node_nxt;
  end

endmodule

[rtl/btn_checker.sv]
// port-level checks for the threshold network engine, bound to the top level
module btn_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               full,
  input logic                               empty,
  input logic                               pop,
  input btn_pkg::out_item_t                 out_item,
  input logic                               psel,
  input logic                               penable,
  input logic                               pwrite,
  input logic [btn_pkg::CFG_ADDR_W-1:0]     paddr,
  input logic [btn_pkg::CFG_DATA_W-1:0]     pwdata,
  input logic [btn_pkg::CFG_DATA_W-1:0]     prdata,
  input logic                               pready
);

  // both queues come out of reset empty
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty && !full)
    else $error("queues not empty after reset");

  // a waiting result holds until it is taken
  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_item))
    else $error("waiting result changed or vanished");

  // a count error is reported alone, as the last result with no spike
  a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_item.size_error |->
      out_item.last_result && !out_item.spike && out_item.out_node == '0)
    else $error("malformed size error result");

  // layer count reads back what was written
  a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable && pwrite && pready && paddr == '0 |=>
      paddr != '0 || prdata[btn_pkg::LC_W-1:0] == $past(pwdata[btn_pkg::LC_W-1:0]))
    else $error("layer count readback mismatch");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready dropped");

endmodule

bind binary_threshold_net_inference_unit btn_checker u_btn_checker (.*);
